@@ src/oisp_pkg.sv @@
// Shared types and codes for the ordered id set pool.
`timescale 1ns / 1ps
`default_nettype none

package oisp_pkg;

   localparam int KIND_BITS      = 2;
   localparam int POS_BITS       = 7;
   localparam int STATUS_BITS    = 3;
   localparam int OUT_COUNT_BITS = 8;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ADD,
      KIND_REMOVE,
      KIND_READ_POS,
      KIND_READ_FIRST
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK,
      STATUS_PRESENT,
      STATUS_FULL,
      STATUS_MISSING,
      STATUS_EMPTY
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SEEK,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_DEL,
      ST_FREE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ src/oisp_ram.sv @@
// Single-port-write, single-port-read slot memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module oisp_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 22,
   parameter int AW    = 7
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/ordered_id_set_pool.sv @@
// Ordered id set pool: linked slot lists walked by a small sequencer.
// Add and remove: lookup walks one slot per cycle (up to the live count of slots), then
// relinks and reports; on an empty pool the walk is skipped.
// Read at position walks to the position; read first reads the head. The walk rate is set
// by the registered read of the slot memories. One item at a time; ready only when idle.
// Reset is synchronous: the pool is empty and ready the cycle after; no memory sweep.
`timescale 1ns / 1ps
`default_nettype none

module ordered_id_set_pool
   import oisp_pkg::*;
#(
   parameter int CAPACITY = 128,
   parameter int ID_BITS  = 22,
   parameter int REQ_W    = ((ID_BITS + POS_BITS + 7) / 8) * 8,
   parameter int RSP_W    = ((STATUS_BITS + ID_BITS + OUT_COUNT_BITS + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_W-1:0]     req_tdata,  // proc_id, position
   input  wire logic [KIND_BITS-1:0] req_tuser,  // kind
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [RSP_W-1:0]     rsp_tdata   // status, id_out, live_count
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

   state_type              state_ff, state_in;
   kind_type               kind_ff, kind_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [IW-1:0]          node_ff, node_in;
   logic [CW-1:0]          step_ff, step_in;
   status_type             status_ff, status_in;
   logic [ID_BITS-1:0]     rid_ff, rid_in;
   logic [IW-1:0]          head_ff, head_in;
   logic [IW-1:0]          tail_ff, tail_in;
   logic [IW-1:0]          fhead_ff, fhead_in;
   logic [IW-1:0]          ftail_ff, ftail_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          wm_ff, wm_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]     rsp_id_ff, rsp_id_in;
   logic [OUT_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic [IW-1:0]          rd_addr;
   logic [ID_BITS-1:0]     id_rd;
   logic [IW-1:0]          nxt_rd;
   logic [IW-1:0]          prv_rd;
   logic                   id_we, next_we, prev_we;
   logic [IW-1:0]          id_waddr, next_waddr, prev_waddr;
   logic [ID_BITS-1:0]     id_wdata;
   logic [IW-1:0]          next_wdata, prev_wdata;

   kind_type               req_kind;
   logic [ID_BITS-1:0]     req_id;
   logic [POS_BITS-1:0]    req_pos;
   logic                   match;
   logic                   fresh;
   logic                   rsp_load;

   assign req_kind = kind_type'(req_tuser);
   assign req_id   = req_tdata[ID_BITS-1:0];
   assign req_pos  = req_tdata[ID_BITS +: POS_BITS];

   // shared compare of the walked slot against the requested id
   assign match = (id_rd == id_ff);
   // slots above the high-water mark still follow the reset chain
   assign fresh = (wm_ff != CW'(CAPACITY));

   oisp_ram #(.DEPTH(CAPACITY), .WIDTH(ID_BITS), .AW(IW)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_waddr),
      .wr_data (id_wdata),
      .rd_addr (rd_addr),
      .rd_data (id_rd)
   );

   oisp_ram #(.DEPTH(CAPACITY), .WIDTH(IW), .AW(IW)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (rd_addr),
      .rd_data (nxt_rd)
   );

   oisp_ram #(.DEPTH(CAPACITY), .WIDTH(IW), .AW(IW)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (rd_addr),
      .rd_data (prv_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fhead_ff     <= '0;
         ftail_ff     <= IW'(CAPACITY - 1);
         count_ff     <= '0;
         wm_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fhead_ff     <= fhead_in;
         ftail_ff     <= ftail_in;
         count_ff     <= count_in;
         wm_ff        <= wm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      pos_ff        <= pos_in;
      node_ff       <= node_in;
      step_ff       <= step_in;
      status_ff     <= status_in;
      rid_ff        <= rid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      pos_in        = pos_ff;
      node_in       = node_ff;
      step_in       = step_ff;
      status_in     = status_ff;
      rid_in        = rid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fhead_in      = fhead_ff;
      ftail_in      = ftail_ff;
      count_in      = count_ff;
      wm_in         = wm_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = node_ff;
      id_we         = 1'b0;
      id_waddr      = node_ff;
      id_wdata      = id_ff;
      next_we       = 1'b0;
      next_waddr    = node_ff;
      next_wdata    = node_ff;
      prev_we       = 1'b0;
      prev_waddr    = node_ff;
      prev_wdata    = node_ff;
      req_tready    = (state_ff == ST_IDLE);
      rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = head_ff;
            if (req_tvalid) begin
               kind_in   = req_kind;
               id_in     = req_id;
               pos_in    = (req_kind == KIND_READ_FIRST) ? '0 : PW'(req_pos);
               node_in   = head_ff;
               step_in   = '0;
               rid_in    = '0;
               status_in = STATUS_OK;
               unique case (req_kind)
                  KIND_ADD: begin
                     state_in = (count_ff == '0) ? ST_ADD_RD : ST_LOOK;
                  end
                  KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_MISSING;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_LOOK;
                     end
                  end
                  KIND_READ_POS: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_DONE;
                     end else if (PW'(req_pos) >= PW'(count_ff)) begin
                        status_in = STATUS_MISSING;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_SEEK;
                     end
                  end
                  KIND_READ_FIRST: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_SEEK;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (match) begin
               if (kind_ff == KIND_ADD) begin
                  status_in = STATUS_PRESENT;
                  state_in  = ST_DONE;
               end else begin
                  // keep reading this slot so its links are on hand next cycle
                  state_in = ST_DEL;
               end
            end else if (step_ff + 1'b1 == count_ff) begin
               if (kind_ff != KIND_ADD) begin
                  status_in = STATUS_MISSING;
                  state_in  = ST_DONE;
               end else if (count_ff == CW'(CAPACITY)) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_ADD_RD;
               end
            end else begin
               node_in = nxt_rd;
               step_in = step_ff + 1'b1;
               rd_addr = nxt_rd;
            end
         end
         ST_SEEK: begin
            if (PW'(step_ff) == pos_ff) begin
               rid_in   = id_rd;
               state_in = ST_DONE;
            end else begin
               node_in = nxt_rd;
               step_in = step_ff + 1'b1;
               rd_addr = nxt_rd;
            end
         end
         ST_ADD_RD: begin
            rd_addr  = fhead_ff;
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            id_we    = 1'b1;
            id_waddr = fhead_ff;
            id_wdata = id_ff;
            if (count_ff < CW'(CAPACITY - 1)) begin
               fhead_in = (fresh && fhead_ff != IW'(CAPACITY - 1)) ?
                          fhead_ff + 1'b1 : nxt_rd;
            end
            if (fresh) begin
               wm_in = wm_ff + 1'b1;
            end
            if (count_ff == '0) begin
               head_in = fhead_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = tail_ff;
               next_wdata = fhead_ff;
               prev_we    = 1'b1;
               prev_waddr = fhead_ff;
               prev_wdata = tail_ff;
            end
            tail_in  = fhead_ff;
            count_in = count_ff + 1'b1;
            state_in = ST_DONE;
         end
         ST_DEL: begin
            if (count_ff <= CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else if (node_ff == head_ff) begin
               head_in = nxt_rd;
            end else if (node_ff == tail_ff) begin
               tail_in = prv_rd;
            end else begin
               next_we    = 1'b1;
               next_waddr = prv_rd;
               next_wdata = nxt_rd;
               prev_we    = 1'b1;
               prev_waddr = nxt_rd;
               prev_wdata = prv_rd;
            end
            count_in = count_ff - 1'b1;
            state_in = ST_FREE;
         end
         ST_FREE: begin
            // free list was empty when the pool was full before the removal
            if (count_ff >= CW'(CAPACITY - 1)) begin
               fhead_in = node_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = ftail_ff;
               next_wdata = node_ff;
            end
            ftail_in = node_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = rid_ff;
               rsp_count_in  = OUT_COUNT_BITS'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_id_ff, rsp_status_ff});

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("live count exceeds capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("accepted item did not start work");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK || state_ff == ST_SEEK) |-> step_ff < count_ff)
      else $error("walk ran past the live list");

   a_free_after_del: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FREE |-> $past(state_ff) == ST_DEL)
      else $error("free-list append without unlink");

   a_add_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD_WR |-> count_ff < CW'(CAPACITY))
      else $error("slot taken from a full pool");

endmodule

`default_nettype wire

@@ tb/sv/ordered_id_set_pool_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the ordered id set pool: table-driven and random set operations.
module ordered_id_set_pool_tb;
   import oisp_pkg::*;

   localparam int CAPACITY     = 128;
   localparam int ID_BITS      = 22;
   localparam int REQ_W        = ((ID_BITS + POS_BITS + 7) / 8) * 8;
   localparam int RSP_W        = ((STATUS_BITS + ID_BITS + OUT_COUNT_BITS + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 476;
   localparam int TAIL_CYCLES  = 200;

   typedef struct {
      status_type                status;
      logic [ID_BITS-1:0]        id_out;
      logic [OUT_COUNT_BITS-1:0] live_count;
   } pool_result_type;

   typedef struct {
      kind_type             kind;
      logic [ID_BITS-1:0]   proc_id;
      logic [POS_BITS-1:0]  position;
      bit                   typed;
      pool_result_type      res;
   } table_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;   // proc_id, position
   logic [KIND_BITS-1:0] req_tuser;   // kind
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;   // status, id_out, live_count

   logic [ID_BITS-1:0] held_ids [$];         // ids in insertion order
   pool_result_type    pending_results [$];
   int                 fails;
   bit                 steady;

   ordered_id_set_pool dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int locate_id(logic [ID_BITS-1:0] id);
      foreach (held_ids[i]) begin
         if (held_ids[i] == id) return i;
      end
      return -1;
   endfunction

   // Apply one operation to the ordered set and return the result it should report.
   function automatic pool_result_type apply_op(kind_type kind, logic [ID_BITS-1:0] id,
                                                logic [POS_BITS-1:0] pos);
      pool_result_type r;
      int              idx;
      r = '{STATUS_OK, '0, '0};
      idx = locate_id(id);
      case (kind)
         KIND_ADD: begin
            if (idx >= 0) r.status = STATUS_PRESENT;
            else if (held_ids.size() >= CAPACITY) r.status = STATUS_FULL;
            else held_ids.push_back(id);
         end
         KIND_REMOVE: begin
            if (idx < 0) r.status = STATUS_MISSING;
            else held_ids.delete(idx);
         end
         KIND_READ_POS: begin
            if (held_ids.size() == 0) r.status = STATUS_EMPTY;
            else if (int'(pos) >= held_ids.size()) r.status = STATUS_MISSING;
            else r.id_out = held_ids[pos];
         end
         default: begin
            if (held_ids.size() == 0) r.status = STATUS_EMPTY;
            else r.id_out = held_ids[0];
         end
      endcase
      r.live_count = OUT_COUNT_BITS'(held_ids.size());
      return r;
   endfunction

   function automatic logic [ID_BITS-1:0] pick_id(int held_pct);
      if (held_ids.size() != 0 && $urandom_range(99) < held_pct)
         return held_ids[$urandom_range(held_ids.size() - 1)];
      if ($urandom_range(4) == 0) return ID_BITS'($urandom_range(31));
      return ID_BITS'($urandom());
   endfunction

   task automatic issue(kind_type kind, logic [ID_BITS-1:0] id, logic [POS_BITS-1:0] pos,
                        bit typed, pool_result_type typed_res);
      pool_result_type predicted;
      while (!steady && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_W'({pos, id});
      do @(posedge clock); while (!req_tready);
      predicted = apply_op(kind, id, pos);
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   // Hold the sender until every outstanding result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 20);
   end

   always @(posedge clock) begin : check_rsp
      pool_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            fails++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[STATUS_BITS-1:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status,
                      rsp_tdata[STATUS_BITS-1:0]);
               fails++;
            end
            if (rsp_tdata[STATUS_BITS +: ID_BITS] !== want.id_out) begin
               $error("id_out: expected %h, got %h", want.id_out,
                      rsp_tdata[STATUS_BITS +: ID_BITS]);
               fails++;
            end
            if (rsp_tdata[STATUS_BITS + ID_BITS +: OUT_COUNT_BITS] !== want.live_count) begin
               $error("live_count: expected %0d, got %0d", want.live_count,
                      rsp_tdata[STATUS_BITS + ID_BITS +: OUT_COUNT_BITS]);
               fails++;
            end
         end
      end
   end

   initial begin
      table_row_type       rows [24];
      pool_result_type     open_res;
      kind_type            kind;
      logic [ID_BITS-1:0]  id;
      logic [POS_BITS-1:0] pos;
      bit                  grow;
      int                  r;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_ADD;
      rsp_tready = 1'b0;
      fails      = 0;
      steady     = 1'b0;
      open_res   = '{STATUS_OK, '0, '0};

      rows = '{
         // empty pool right after reset
         '{KIND_READ_FIRST, 22'h155555, 7'd0,   1'b1, '{STATUS_EMPTY,   22'h0,      8'd0}},
         '{KIND_READ_POS,   22'h000000, 7'd0,   1'b1, '{STATUS_EMPTY,   22'h0,      8'd0}},
         '{KIND_READ_POS,   22'h3FFFFF, 7'd127, 1'b1, '{STATUS_EMPTY,   22'h0,      8'd0}},
         '{KIND_REMOVE,     22'h3FFFFF, 7'd0,   1'b1, '{STATUS_MISSING, 22'h0,      8'd0}},
         '{KIND_ADD,        22'h3FFFFF, 7'd0,   1'b1, '{STATUS_OK,      22'h0,      8'd1}},
         '{KIND_ADD,        22'h3FFFFF, 7'd0,   1'b1, '{STATUS_PRESENT, 22'h0,      8'd1}},
         '{KIND_ADD,        22'h000000, 7'd0,   1'b1, '{STATUS_OK,      22'h0,      8'd2}},
         '{KIND_ADD,        22'h2AAAAA, 7'd0,   1'b1, '{STATUS_OK,      22'h0,      8'd3}},
         '{KIND_READ_FIRST, 22'h000000, 7'd0,   1'b1, '{STATUS_OK,      22'h3FFFFF, 8'd3}},
         '{KIND_READ_POS,   22'h3FFFFF, 7'd1,   1'b1, '{STATUS_OK,      22'h000000, 8'd3}},
         '{KIND_READ_POS,   22'h000000, 7'd2,   1'b1, '{STATUS_OK,      22'h2AAAAA, 8'd3}},
         '{KIND_READ_POS,   22'h000000, 7'd3,   1'b1, '{STATUS_MISSING, 22'h0,      8'd3}},
         '{KIND_READ_POS,   22'h000000, 7'd127, 1'b1, '{STATUS_MISSING, 22'h0,      8'd3}},
         // unlink from the middle, then head, then tail
         '{KIND_REMOVE,     22'h000000, 7'd0,   1'b1, '{STATUS_OK,      22'h0,      8'd2}},
         '{KIND_READ_POS,   22'h155555, 7'd1,   1'b0, open_res},
         '{KIND_REMOVE,     22'h3FFFFF, 7'd0,   1'b1, '{STATUS_OK,      22'h0,      8'd1}},
         '{KIND_READ_FIRST, 22'h2AAAAA, 7'd5,   1'b0, open_res},
         '{KIND_ADD,        22'h155555, 7'd0,   1'b0, open_res},
         '{KIND_REMOVE,     22'h155555, 7'd0,   1'b0, open_res},
         '{KIND_REMOVE,     22'h2AAAAA, 7'd0,   1'b1, '{STATUS_OK,      22'h0,      8'd0}},
         '{KIND_REMOVE,     22'h2AAAAA, 7'd0,   1'b1, '{STATUS_MISSING, 22'h0,      8'd0}},
         '{KIND_READ_FIRST, 22'h3FFFFF, 7'd0,   1'b1, '{STATUS_EMPTY,   22'h0,      8'd0}},
         '{KIND_ADD,        22'h000001, 7'd0,   1'b0, open_res},
         '{KIND_READ_POS,   22'h3FFFFF, 7'd0,   1'b0, open_res}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         issue(rows[i].kind, rows[i].proc_id, rows[i].position, rows[i].typed, rows[i].res);
      end
      drain();

      // Grow toward a full pool, linger there, then shrink back to empty, and repeat.
      grow = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 300 && n < 380);
         r = $urandom_range(99);
         if (grow) begin
            kind = (r < 70) ? KIND_ADD : (r < 80) ? KIND_REMOVE :
                   (r < 90) ? KIND_READ_POS : KIND_READ_FIRST;
         end else begin
            kind = (r < 70) ? KIND_REMOVE : (r < 80) ? KIND_ADD :
                   (r < 90) ? KIND_READ_POS : KIND_READ_FIRST;
         end
         if (kind == KIND_ADD) id = pick_id(15);
         else if (kind == KIND_REMOVE) id = pick_id(75);
         else id = ID_BITS'($urandom());
         // aim reads at the last valid place and one past it
         if ($urandom_range(3) == 0 && held_ids.size() != 0) begin
            pos = $urandom_range(1) ? POS_BITS'(held_ids.size() - 1) :
                                      POS_BITS'(held_ids.size());
         end else begin
            pos = POS_BITS'($urandom_range(127));
         end
         issue(kind, id, pos, 1'b0, open_res);
         if (grow && held_ids.size() == CAPACITY && $urandom_range(5) == 0) begin
            grow = 1'b0;
            drain();
         end else if (!grow && held_ids.size() == 0 && $urandom_range(3) == 0) begin
            grow = 1'b1;
            drain();
         end
      end
      steady = 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
